/* rtl/csvfst_pkg.sv */
// ----------------------------------------------------------------------------
// csvfst_pkg
// Shared types, constants and byte classifiers for the csv field splitter.
// ----------------------------------------------------------------------------
package csvfst_pkg;

  typedef logic [7:0] byte_t;

  // register map, word index
  localparam logic REG_DELIMITER = 1'b0;

  localparam byte_t DELIM_RESET  = 8'd44;
  localparam byte_t QUOTE_DOUBLE = 8'h22;
  localparam byte_t QUOTE_SINGLE = 8'h27;

  // input item codes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_ROW_END = 1'b1;

  function automatic logic is_blank(input byte_t b);
    is_blank = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  function automatic logic is_quote(input byte_t b);
    is_quote = (b == QUOTE_DOUBLE) || (b == QUOTE_SINGLE);
  endfunction

endpackage

/* rtl/csv_field_splitter_trim_unit.sv */
// ----------------------------------------------------------------------------
// csv_field_splitter_trim_unit
// Splits a streamed text row at a delimiter byte and reports each field as
// a trimmed view (offset, length) into the row, quotes stripped from ends.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_op, in_data_byte
//  out_     output     out_valid/out_stall out_field_offset, out_field_length,
//                                          out_field_number, out_row_last,
//                                          out_field_overflow
//  cfg      apb        psel/penable/pready paddr, pwrite, pwdata, prdata
//
// a data byte is taken while idle; a delimiter or row end runs its end-pair
// compares (pairs stripped, plus one when the last compare fails), each a
// store read and a compare of the two ends, before the field is finished.
// in_stall is high while a field is closed, and stays high while a full
// output register is stalled. a finished field sits in the output register
// while the next byte is taken.
// rst_n is synchronous, active low; the field store needs no clearing.
// ----------------------------------------------------------------------------
module csv_field_splitter_trim_unit #(
  parameter int FIELD_DEPTH = 256,
  parameter int ROW_LIMIT   = 65536
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  csvfst_pkg::byte_t  in_data_byte,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_field_offset,
  output logic [15:0]        out_field_length,
  output logic [7:0]         out_field_number,
  output logic               out_row_last,
  output logic               out_field_overflow,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import csvfst_pkg::*;

  localparam int ADDR_W = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
  localparam int FILL_W = $clog2(FIELD_DEPTH + 1);
  localparam int POS_W  = $clog2(ROW_LIMIT + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // field store and its registered read ports
  byte_t              mem [FIELD_DEPTH];
  byte_t              rd_a_r;
  byte_t              rd_b_r;
  logic               mem_we;

  logic [1:0]         state_r, state_nxt;
  byte_t              delim_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   begin_r, begin_nxt;
  logic [POS_W-1:0]   first_r, first_nxt;
  logic [POS_W-1:0]   last_r, last_nxt;
  logic               seen_r, seen_nxt;
  logic               over_r, over_nxt;
  logic [7:0]         count_r, count_nxt;
  logic               row_end_r, row_end_nxt;

  logic [ADDR_W-1:0]  s_r, s_nxt;
  logic [ADDR_W-1:0]  e_r, e_nxt;
  logic [POS_W-1:0]   len_r, len_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_off_r, out_off_nxt;
  logic [POS_W-1:0]   out_len_r, out_len_nxt;
  logic [7:0]         out_num_r, out_num_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               in_xfer;
  logic               limited;
  logic               cfg_write;
  logic [POS_W-1:0]   s_init;
  logic [POS_W-1:0]   e_init;
  logic [31:0]        s_row;
  logic [31:0]        off_ext;
  logic [31:0]        len_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign limited   = (pos_r >= POS_W'(ROW_LIMIT));
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DELIMITER);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DELIMITER) ? {24'd0, delim_r} : 32'd0;

  assign s_init = first_r - begin_r;
  assign e_init = last_r - begin_r;
  assign s_row  = 32'(begin_r) + 32'(s_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    begin_nxt     = begin_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    seen_nxt      = seen_r;
    over_nxt      = over_r;
    count_nxt     = count_r;
    row_end_nxt   = row_end_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    out_off_nxt   = out_off_r;
    out_len_nxt   = out_len_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_op == OP_ROW_END) || (!limited && (in_data_byte == delim_r))) begin
            // close the field: set up the quote strip window
            row_end_nxt = (in_op == OP_ROW_END);
            s_nxt       = ADDR_W'(32'(s_init));
            e_nxt       = ADDR_W'(32'(e_init));
            len_nxt     = last_r - first_r + POS_W'(1);
            if (seen_r && !over_r && ((last_r - first_r) != '0)) begin
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_FIN;
            end
          end else if (!limited) begin
            if (fill_r < FILL_W'(FIELD_DEPTH)) begin
              mem_we   = 1'b1;
              fill_nxt = fill_r + FILL_W'(1);
            end else begin
              over_nxt = 1'b1;
            end
            if (!is_blank(in_data_byte)) begin
              if (!seen_r) begin
                first_nxt = pos_r;
                seen_nxt  = 1'b1;
              end
              last_nxt = pos_r;
            end
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if ((rd_a_r == rd_b_r) && is_quote(rd_a_r)) begin
          s_nxt   = s_r + ADDR_W'(1);
          e_nxt   = e_r - ADDR_W'(1);
          len_nxt = len_r - POS_W'(2);
          if (len_r >= POS_W'(4)) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (seen_r) begin
            out_off_nxt = over_r ? first_r : s_row[POS_W-1:0];
            out_len_nxt = len_r;
          end else begin
            out_off_nxt = pos_r;
            out_len_nxt = '0;
          end
          out_num_nxt  = count_r;
          out_last_nxt = row_end_r;
          out_ovf_nxt  = over_r;
          if (row_end_r) begin
            count_nxt = '0;
            pos_nxt   = '0;
            begin_nxt = '0;
          end else begin
            count_nxt = (count_r != 8'd255) ? count_r + 8'd1 : count_r;
            pos_nxt   = pos_r + POS_W'(1);
            begin_nxt = pos_r + POS_W'(1);
          end
          fill_nxt  = '0;
          first_nxt = '0;
          last_nxt  = '0;
          seen_nxt  = 1'b0;
          over_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      delim_r     <= DELIM_RESET;
      fill_r      <= '0;
      pos_r       <= '0;
      begin_r     <= '0;
      first_r     <= '0;
      last_r      <= '0;
      seen_r      <= 1'b0;
      over_r      <= 1'b0;
      count_r     <= '0;
      row_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_write) begin
        delim_r <= pwdata[7:0];
      end
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      begin_r     <= begin_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      seen_r      <= seen_nxt;
      over_r      <= over_nxt;
      count_r     <= count_nxt;
      row_end_r   <= row_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    len_r      <= len_nxt;
    out_off_r  <= out_off_nxt;
    out_len_r  <= out_len_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[ADDR_W-1:0]] <= in_data_byte;
    end
    rd_a_r <= mem[s_r];
    rd_b_r <= mem[e_r];
  end

  assign off_ext = 32'(out_off_r);
  assign len_ext = 32'(out_len_r);

  assign out_valid          = out_valid_r;
  assign out_field_offset   = off_ext[15:0];
  assign out_field_length   = len_ext[15:0];
  assign out_field_number   = out_num_r;
  assign out_row_last       = out_last_r;
  assign out_field_overflow = out_ovf_r;

endmodule

/* bench/csv_field_view_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csv_field_view_checker
// Watches the byte, field and register channels of the csv field splitter,
// predicts the trimmed field view that each delimiter or row end produces,
// and compares every field transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module csv_field_view_checker #(
  parameter int FIELD_DEPTH = 256,
  parameter int ROW_LIMIT   = 65536
) (
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_op,
  input  csvfst_pkg::byte_t in_data_byte,

  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [15:0]       out_field_offset,
  input  logic [15:0]       out_field_length,
  input  logic [7:0]        out_field_number,
  input  logic              out_row_last,
  input  logic              out_field_overflow,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,

  output int                fail_count,
  output int                pending_fields
);

  import csvfst_pkg::*;

  localparam logic [2:0] DELIM_ADDR = {REG_DELIMITER, 2'b00};
  localparam int FILL_W = $clog2(FIELD_DEPTH + 1);
  localparam int POS_W  = $clog2(ROW_LIMIT + 1);

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] length;
    logic [7:0]  number;
    logic        last;
    logic        overflow;
  } field_view_t;

  // shadow of the splitter state
  byte_t              raw_bytes [FIELD_DEPTH];
  logic [FILL_W-1:0]  raw_fill;
  logic [POS_W-1:0]   row_pos;
  logic [POS_W-1:0]   field_start;
  logic [POS_W-1:0]   first_text;
  logic [POS_W-1:0]   last_text;
  logic               has_text;
  logic               too_long;
  logic [7:0]         fields_in_row;
  byte_t              delimiter;

  field_view_t        expected_views [$];

  initial begin
    fail_count     = 0;
    pending_fields = 0;
  end

  function automatic logic is_space(input byte_t b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  task automatic begin_field();
    field_start = row_pos;
    raw_fill    = '0;
    first_text  = '0;
    last_text   = '0;
    has_text    = 1'b0;
    too_long    = 1'b0;
  endtask

  // trim whitespace, then peel matching quote pairs off both ends
  task automatic close_field(input logic is_last);
    logic [POS_W-1:0] lead;
    logic [POS_W-1:0] span;
    logic [POS_W-1:0] tail;
    field_view_t      view;
    if (has_text) begin
      span = last_text - first_text + 1'b1;
      view.offset = 16'(first_text);
      if (!too_long) begin
        lead = first_text - field_start;
        while (span >= 2) begin
          tail = lead + span - 1'b1;
          if (tail >= raw_fill || tail >= FIELD_DEPTH) break;
          if (raw_bytes[lead] != raw_bytes[tail]) break;
          if (raw_bytes[lead] != QUOTE_DOUBLE && raw_bytes[lead] != QUOTE_SINGLE) break;
          lead = lead + 1'b1;
          span = span - 2'd2;
        end
        view.offset = 16'(field_start + lead);
      end
      view.length = 16'(span);
    end else begin
      view.offset = 16'(row_pos);
      view.length = 16'd0;
    end
    view.number   = fields_in_row;
    view.last     = is_last;
    view.overflow = too_long;
    if (fields_in_row != 8'd255) fields_in_row = fields_in_row + 1'b1;
    expected_views.insert(expected_views.size(), view);
  endtask

  task automatic take_byte(input logic op, input byte_t b);
    if (op == OP_ROW_END) begin
      close_field(1'b1);
      row_pos       = '0;
      fields_in_row = 8'd0;
      begin_field();
    end else if (row_pos < ROW_LIMIT) begin
      if (b == delimiter) begin
        close_field(1'b0);
        row_pos = row_pos + 1'b1;
        begin_field();
      end else begin
        if (raw_fill < FIELD_DEPTH) begin
          raw_bytes[raw_fill] = b;
          raw_fill = raw_fill + 1'b1;
        end else begin
          too_long = 1'b1;
        end
        if (!is_space(b)) begin
          if (!has_text) begin
            first_text = row_pos;
            has_text   = 1'b1;
          end
          last_text = row_pos;
        end
        row_pos = row_pos + 1'b1;
      end
    end
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: field %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    field_view_t want;
    if (!rst_n) begin
      row_pos       = '0;
      fields_in_row = 8'd0;
      delimiter     = DELIM_RESET;
      begin_field();
      expected_views.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected field transfer, expected none, actual offset %0d length %0d",
                   $time, out_field_offset, out_field_length);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          compare_field("offset", want.offset, out_field_offset);
          compare_field("length", want.length, out_field_length);
          compare_field("number", want.number, out_field_number);
          compare_field("row_last", want.last, out_row_last);
          compare_field("overflow", want.overflow, out_field_overflow);
        end
      end
      if (psel && penable && pwrite && pready && paddr == DELIM_ADDR)
        delimiter = pwdata[7:0];
      if (in_valid && !in_stall)
        take_byte(in_op, in_data_byte);
    end
    pending_fields = expected_views.size();
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams text rows into the csv field splitter under several delimiters,
// with random sender bursts and receiver stalls; a side checker predicts and
// compares every field view.
// ----------------------------------------------------------------------------
module testbench;
  import csvfst_pkg::*;

  localparam int FIELD_DEPTH   = 256;
  localparam int ROW_LIMIT     = 65536;
  localparam int SETTLE_CYCLES = FIELD_DEPTH + 16;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int PHASE_ITEMS   = 280;
  localparam logic [2:0] DELIM_ADDR = {REG_DELIMITER, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_DATA;
  byte_t       in_data_byte = 8'd0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_field_offset;
  logic [15:0] out_field_length;
  logic [7:0]  out_field_number;
  logic        out_row_last;
  logic        out_field_overflow;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending_fields;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          items_sent = 0;
  byte_t       active_delim = DELIM_RESET;

  csv_field_splitter_trim_unit #(
    .FIELD_DEPTH (FIELD_DEPTH),
    .ROW_LIMIT   (ROW_LIMIT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_field_offset   (out_field_offset),
    .out_field_length   (out_field_length),
    .out_field_number   (out_field_number),
    .out_row_last       (out_row_last),
    .out_field_overflow (out_field_overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  csv_field_view_checker #(
    .FIELD_DEPTH (FIELD_DEPTH),
    .ROW_LIMIT   (ROW_LIMIT)
  ) checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_field_offset   (out_field_offset),
    .out_field_length   (out_field_length),
    .out_field_number   (out_field_number),
    .out_row_last       (out_row_last),
    .out_field_overflow (out_field_overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .pready             (pready),
    .fail_count         (fail_count),
    .pending_fields     (pending_fields)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver: switches between free flow, light and heavy random stall, long holds
  initial begin : field_receiver
    int mode;
    int span;
    int hold;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(50, 300);
      while (span > 0) begin
        hold = 1;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom % 4 == 0);
          2: out_stall <= ($urandom % 4 != 0);
          default: begin
            hold = out_stall ? $urandom_range(1, 10) : $urandom_range(1, 30);
            out_stall <= ~out_stall;
          end
        endcase
        repeat (hold) @(posedge clk);
        span -= hold;
      end
    end
  end

  // one byte transfer; gaps come between bursts
  task automatic send_item(input logic op, input byte_t b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_data_byte <= b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(OP_DATA, byte_t'(s[i]));
  endtask

  task automatic end_row();
    send_item(OP_ROW_END, byte_t'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_fields != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_delimiter(input byte_t value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= DELIM_ADDR;
    pwdata  <= {24'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    active_delim = value;
  endtask

  function automatic byte_t blank_byte();
    byte_t b;
    b = byte_t'($urandom_range(8, 13));
    return (b == 8'd8) ? 8'd32 : b;
  endfunction

  function automatic byte_t quote_byte();
    return ($urandom % 2) ? QUOTE_DOUBLE : QUOTE_SINGLE;
  endfunction

  // field content that never splits the field
  function automatic byte_t text_byte();
    byte_t b;
    do begin
      case ($urandom % 6)
        0, 1, 2: b = byte_t'(8'd97 + $urandom % 26);
        3:       b = blank_byte();
        4:       b = quote_byte();
        default: b = byte_t'($urandom);
      endcase
    end while (b == active_delim);
    return b;
  endfunction

  task automatic send_field(input int kind);
    byte_t outer;
    byte_t inner;
    outer = quote_byte();
    inner = (outer == QUOTE_DOUBLE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
    case (kind)
      0: ;
      1: repeat ($urandom_range(1, 4)) send_item(OP_DATA, blank_byte());
      2: repeat ($urandom_range(1, 8)) send_item(OP_DATA, text_byte());
      3: begin
        repeat ($urandom_range(0, 2)) send_item(OP_DATA, blank_byte());
        send_item(OP_DATA, outer);
        repeat ($urandom_range(0, 6)) send_item(OP_DATA, text_byte());
        send_item(OP_DATA, outer);
        repeat ($urandom_range(0, 2)) send_item(OP_DATA, blank_byte());
      end
      4: begin
        repeat ($urandom_range(0, 2)) send_item(OP_DATA, blank_byte());
        send_item(OP_DATA, outer);
        send_item(OP_DATA, inner);
        repeat ($urandom_range(0, 4)) send_item(OP_DATA, text_byte());
        send_item(OP_DATA, inner);
        send_item(OP_DATA, outer);
        repeat ($urandom_range(0, 2)) send_item(OP_DATA, blank_byte());
      end
      5: begin
        send_item(OP_DATA, outer);
        repeat ($urandom_range(0, 4)) send_item(OP_DATA, text_byte());
        send_item(OP_DATA, inner);
      end
      6: begin
        send_item(OP_DATA, outer);
        repeat ($urandom_range(0, 4)) send_item(OP_DATA, text_byte());
      end
      7: repeat ($urandom_range(0, 10)) send_item(OP_DATA, byte_t'($urandom));
      8: begin
        // around the store depth: fits or overflows
        send_item(OP_DATA, outer);
        repeat ($urandom_range(FIELD_DEPTH - 6, FIELD_DEPTH + 4)) send_item(OP_DATA, text_byte());
        send_item(OP_DATA, outer);
      end
      default: repeat ($urandom_range(1, 2)) send_item(OP_DATA, outer);
    endcase
  endtask

  task automatic send_row(input int n_fields, input bit brief);
    int kind;
    for (int i = 0; i < n_fields; i++) begin
      if (i != 0) send_item(OP_DATA, active_delim);
      if (brief) begin
        // mostly empty fields keep long rows short
        kind = ($urandom % 8 == 0) ? 2 : 0;
      end else begin
        kind = $urandom % 10;
        if (kind == 8 && $urandom % 4 != 0) kind = 3;
      end
      send_field(kind);
    end
    end_row();
  endtask

  initial begin : byte_source
    byte_t plan [6];
    int target;
    int r;
    plan = '{8'd0, 8'd255, 8'd9, QUOTE_DOUBLE, byte_t'($urandom), DELIM_RESET};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under the reset delimiter
    end_row();
    send_text(" \"a\" ,");
    for (int b = 9; b <= 13; b++) send_item(OP_DATA, byte_t'(b));
    send_item(OP_DATA, 8'd32);
    send_item(OP_DATA, DELIM_RESET);
    send_text("'\"x\"'");
    end_row();
    send_item(OP_DATA, QUOTE_DOUBLE);
    send_item(OP_DATA, DELIM_RESET);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    end_row();

    for (int ph = 0; ph < 6; ph++) begin
      write_delimiter(plan[ph]);
      target = items_sent + PHASE_ITEMS;
      // field number saturation
      if (ph == 2) send_row($urandom_range(257, 270), 1'b1);
      while (items_sent < target) begin
        r = $urandom % 32;
        if (r == 0) begin
          drain();
        end else if (r == 1) begin
          repeat ($urandom_range(1, 20))
            send_item(($urandom % 8 == 0) ? OP_ROW_END : OP_DATA, byte_t'($urandom));
        end else begin
          send_row($urandom_range(1, 6), 1'b0);
        end
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
